@@ design/scrgb8_pkg.sv @@
`timescale 1ns / 1ps
package scrgb8_pkg;

  // register indexes of the configuration port
  localparam logic REG_INPUT_MODE = 1'b0;
  localparam logic REG_WHITE_GAIN = 1'b1;

  // input modes
  localparam logic MODE_BYTES = 1'b0;
  localparam logic MODE_HALF  = 1'b1;

  localparam logic [15:0] GAIN_UNITY = 16'd4096;

  // largest fraction code that stays on the linear part of the curve
  localparam logic [15:0] LIN_LAST = 16'd205;

  // decoded channel: forced zero, saturated, or a 16-bit fraction
  typedef struct packed {
    logic        zero;
    logic        sat;
    logic [15:0] q;
  } frac_t;

  // smallest fraction reaching each code on the power part of the curve
  typedef logic [16:0] thr_tab_t [256];

  function automatic thr_tab_t build_thr();
    thr_tab_t    t;
    logic [255:0] c;
    logic [255:0] l;
    logic [255:0] r;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    c = 256'd1;
    for (int i = 0; i < 12; i++) c = c * 256'd10761;
    t[0] = 17'd0;
    for (int k = 1; k < 256; k++) begin
      r = 256'd1;
      for (int i = 0; i < 12; i++) r = r * 256'(40 * k + 541);
      r = r << 80;
      lo = 206;
      hi = 65536;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        l = 256'd1;
        for (int i = 0; i < 5; i++) l = l * 256'(mid);
        l = l * c;
        if (l >= r) hi = mid;
        else lo = mid + 1;
      end
      t[k] = 17'(lo);
    end
    return t;
  endfunction

  localparam thr_tab_t THR = build_thr();

endpackage

@@ design/scrgb8_decode.sv @@
`timescale 1ns / 1ps
module scrgb8_decode import scrgb8_pkg::*; (
  input  logic [15:0] half_i,
  input  logic [15:0] gain_i,
  output frac_t       frac_o
);

  logic        sign;
  logic [4:0]  ex;
  logic [9:0]  man;
  logic [4:0]  e;
  logic [10:0] sig;
  logic [15:0] gain;
  logic [26:0] prod;
  logic [35:0] wide;
  logic [4:0]  sh;

  // field split
  assign sign = half_i[15];
  assign ex   = half_i[14:10];
  assign man  = half_i[9:0];
  assign e    = (ex == 5'd0) ? 5'd1 : ex;
  assign sig  = {(ex != 5'd0), man};
  assign gain = (gain_i == 16'd0) ? GAIN_UNITY : gain_i;

  // scale and align to a 16-bit fraction
  assign prod = 27'(sig) * 27'(gain);
  assign sh   = 5'd30 - e;
  assign wide = {prod, 9'd0} >> sh;

  // special values
  always_comb begin
    frac_o.q    = wide[15:0];
    frac_o.zero = 1'b0;
    frac_o.sat  = 1'b0;
    if (sign) begin
      frac_o.zero = 1'b1;
    end else if (ex == 5'd31) begin
      frac_o.zero = (man != 10'd0);
      frac_o.sat  = (man == 10'd0);
    end else if (ex == 5'd0 && man == 10'd0) begin
      frac_o.zero = 1'b1;
    end else begin
      frac_o.sat = (wide[35:16] != 20'd0);
    end
  end

endmodule

@@ design/scrgb8_encode.sv @@
`timescale 1ns / 1ps
module scrgb8_encode import scrgb8_pkg::*; (
  input  frac_t      frac_i,
  output logic [7:0] code_o
);

  logic [23:0] lin_sum;
  logic [7:0]  lin_hi;
  logic [18:0] lin_div;
  logic [7:0]  pow_code;
  logic [7:0]  cand;

  // linear segment: (q * 32946 + 327680) / 655360
  assign lin_sum = 24'(frac_i.q[7:0] * 24'd32946) + 24'd327680;
  assign lin_hi  = lin_sum[23:16];
  assign lin_div = 19'(lin_hi) * 19'd205;

  // power segment: binary search over the threshold table
  always_comb begin
    pow_code = 8'd0;
    cand     = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      cand = pow_code | (8'd1 << b);
      if (THR[cand] <= {1'b0, frac_i.q}) pow_code = cand;
    end
  end

  always_comb begin
    if (frac_i.zero) code_o = 8'd0;
    else if (frac_i.sat) code_o = 8'd255;
    else if (frac_i.q <= LIN_LAST) code_o = lin_div[18:11];
    else code_o = pow_code;
  end

endmodule

@@ design/scrgb_half_to_srgb8_pixel.sv @@
`timescale 1ns / 1ps
// scRGB half / BGRA byte pixel to packed 8-bit sRGB converter
//
// request channel: a pixel is taken at a clock edge with start high and
// busy low; busy stays low, so one pixel can enter every cycle
// result channel: valid_o is high for exactly one cycle with red_o,
// green_o, blue_o and frame_end_out_o; the receiver cannot stall it
// configuration: cfg_valid_i / cfg_ready_o write channel, cfg_index_i
// selects input_mode (0) or white_gain (1); cfg_ready_o is always high
// registers in order: input register, gain multiply register, result
// register; throughput one pixel per cycle; the gain multiplier and the
// 8-step sRGB threshold search each fill one register-to-register stage
// the mode is sampled with each pixel at the input register
// reset clears the pipeline valid bits and sets input_mode to bytes and
// white_gain to unity; no pass over any memory is needed
module scrgb_half_to_srgb8_pixel import scrgb8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] first_channel_i,
  input  logic [15:0] second_channel_i,
  input  logic [15:0] third_channel_i,
  input  logic        frame_end_in_i,
  output logic        valid_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        frame_end_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic        mode_q;
  logic [15:0] gain_q;
  logic        v1_q, v2_q, v3_q;
  logic        m1_q, m2_q;
  logic        fe1_q, fe2_q, fe3_q;
  logic [15:0] ch_q [3];
  logic [7:0]  byte_q [3];
  frac_t       frac_d [3];
  frac_t       frac_q [3];
  logic [7:0]  code [3];
  logic [7:0]  res_q [3];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BYTES;
      gain_q <= GAIN_UNITY;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_INPUT_MODE) mode_q <= cfg_data_i[0];
      else gain_q <= cfg_data_i;
    end
  end

  // valid bits of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    ch_q[0] <= first_channel_i;
    ch_q[1] <= second_channel_i;
    ch_q[2] <= third_channel_i;
    m1_q    <= mode_q;
    fe1_q   <= frame_end_in_i;
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    scrgb8_decode u_dec (
      .half_i(ch_q[c]),
      .gain_i(gain_q),
      .frac_o(frac_d[c])
    );
    scrgb8_encode u_enc (
      .frac_i(frac_q[c]),
      .code_o(code[c])
    );
  end

  // fraction register
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      frac_q[c] <= frac_d[c];
      byte_q[c] <= ch_q[c][7:0];
    end
    m2_q  <= m1_q;
    fe2_q <= fe1_q;
  end

  // result register, bytes reordered from BGR to RGB in byte mode
  always_ff @(posedge clk_i) begin
    if (m2_q == MODE_HALF) begin
      res_q[0] <= code[0];
      res_q[1] <= code[1];
      res_q[2] <= code[2];
    end else begin
      res_q[0] <= byte_q[2];
      res_q[1] <= byte_q[1];
      res_q[2] <= byte_q[0];
    end
    fe3_q <= fe2_q;
  end

  assign valid_o         = v3_q;
  assign red_o           = res_q[0];
  assign green_o         = res_q[1];
  assign blue_o          = res_q[2];
  assign frame_end_out_o = fe3_q;

endmodule

@@ design/scrgb8_checker.sv @@
`timescale 1ns / 1ps
module scrgb8_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       valid_o,
  input logic       frame_end_in_i,
  input logic       frame_end_out_o
);

  // every request gives a result once it has passed the pipeline valid registers
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 valid_o)
    else $error("request without result");

  // no result without a request
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(rst_ni, 3)) |-> $past(start && !busy, 3))
    else $error("result without request");

  // frame end mark follows its pixel
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (frame_end_out_o == $past(frame_end_in_i, 3)))
    else $error("frame end mark lost");

endmodule

bind scrgb_half_to_srgb8_pixel scrgb8_checker u_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .start(start),
  .busy(busy),
  .valid_o(valid_o),
  .frame_end_in_i(frame_end_in_i),
  .frame_end_out_o(frame_end_out_o)
);
